// ----- hw/rtl/kvt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and helpers of the key/value table
// Opcodes, status codes, controller states, the command broadcast to the
// cells and the record that travels along the chain of cells.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int WORD_W          = 64;
    localparam int DEF_ENTRIES     = 16;
    localparam int DEF_KEY_BYTES   = 8;
    localparam int DEF_VALUE_BYTES = 8;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_DEL   = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                commit;
        opcode_t             op;
        logic                found;
        logic [WORD_W-1:0]   key;
        logic [WORD_W-1:0]   value;
        logic [WORD_W-1:0]   last_key;
        logic [WORD_W-1:0]   last_value;
    } cmd_t;

    typedef struct packed {
        logic                hit;
        logic [WORD_W-1:0]   value;
        logic [WORD_W-1:0]   last_key;
        logic [WORD_W-1:0]   last_value;
    } chain_t;

    // Keep the bytes before the first zero byte, within nbytes bytes.
    function automatic logic [WORD_W-1:0] canon_word(input logic [WORD_W-1:0] w,
                                                     input int nbytes);
        logic [WORD_W-1:0] res;
        logic              stop;
        logic [7:0]        b;
        res  = '0;
        stop = 1'b0;
        for (int i = 0; i < WORD_W / 8; i++) begin
            b = w[8*i +: 8];
            if (i < nbytes && !stop) begin
                if (b == 8'd0) begin
                    stop = 1'b1;
                end
                else begin
                    res[8*i +: 8] = b;
                end
            end
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/kvt_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_req_if: request channel of the key/value table
// Valid/ready channel carrying opcode, key and value of one request.
// ----------------------------------------------------------------------------
interface kvt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] search_key;
    logic [63:0] data_word;

    modport source (output valid, output opcode, output search_key, output data_word,
                    input ready);
    modport sink   (input valid, input opcode, input search_key, input data_word,
                    output ready);
endinterface

// ----- hw/rtl/kvt_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_rsp_if: response channel of the key/value table
// Valid/ready channel carrying status and read data of one response.
// ----------------------------------------------------------------------------
interface kvt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] read_data;

    modport source (output valid, output status, output read_data, input ready);
    modport sink   (input valid, input status, input read_data, output ready);
endinterface

// ----- hw/rtl/kvt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_cell: one entry of the key/value table
// Holds one key/value pair, compares it against the broadcast key, merges
// its hit and last-entry data into the chain record and applies the commit.
// ----------------------------------------------------------------------------
module kvt_cell #(
    parameter int KEY_W   = kvt_pkg::DEF_KEY_BYTES * 8,
    parameter int VALUE_W = kvt_pkg::DEF_VALUE_BYTES * 8,
    parameter int CNT_W   = $clog2(kvt_pkg::DEF_ENTRIES + 1)
) (
    input  logic                 clk,
    input  kvt_pkg::cmd_t        cmd,
    input  logic [CNT_W-1:0]     index,
    input  logic [CNT_W-1:0]     count,
    input  kvt_pkg::chain_t      chain_in,
    output kvt_pkg::chain_t      chain_out
);

    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    kvt_pkg::chain_t    chain_reg;
    kvt_pkg::chain_t    chain_next;

    logic live;
    logic is_last;
    logic is_append;
    logic hit;

    assign live      = index < count;
    assign is_last   = live && (index == count - 1'b1);
    assign is_append = index == count;
    assign hit       = live && (key_reg == cmd.key[KEY_W-1:0]);

    always_comb
    begin
        chain_next = chain_in;
        if (hit)
        begin
            chain_next.hit   = 1'b1;
            chain_next.value = kvt_pkg::WORD_W'(value_reg);
        end
        if (is_last)
        begin
            chain_next.last_key   = kvt_pkg::WORD_W'(key_reg);
            chain_next.last_value = kvt_pkg::WORD_W'(value_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
        if (cmd.commit)
        begin
            unique case (cmd.op)
                kvt_pkg::OP_PUT:
                begin
                    if (cmd.found ? hit : is_append)
                    begin
                        key_reg   <= cmd.key[KEY_W-1:0];
                        value_reg <= cmd.value[VALUE_W-1:0];
                    end
                end
                kvt_pkg::OP_DEL:
                begin
                    if (hit)
                    begin
                        key_reg   <= cmd.last_key[KEY_W-1:0];
                        value_reg <= cmd.last_value[VALUE_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign chain_out = chain_reg;

endmodule

// ----- hw/rtl/kvt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_ctrl: request sequencer of the key/value table
// Takes a request, broadcasts a put, get or delete while the chain sweeps,
// commits it, keeps the entry count and drives the registered response.
// ----------------------------------------------------------------------------
module kvt_ctrl #(
    parameter int ENTRIES     = kvt_pkg::DEF_ENTRIES,
    parameter int KEY_BYTES   = kvt_pkg::DEF_KEY_BYTES,
    parameter int VALUE_BYTES = kvt_pkg::DEF_VALUE_BYTES,
    parameter int CNT_W       = $clog2(ENTRIES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    kvt_req_if.sink           req,
    kvt_rsp_if.source         rsp,
    input  kvt_pkg::chain_t   chain_res,
    output kvt_pkg::cmd_t     cmd,
    output logic [CNT_W-1:0]  count
);

    kvt_pkg::state_t  state_reg, state_next;
    kvt_pkg::opcode_t op_reg, op_next;
    logic [kvt_pkg::WORD_W-1:0] key_reg, key_next;
    logic [kvt_pkg::WORD_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] sweep_reg, sweep_next;
    kvt_pkg::status_t res_status_reg, res_status_next;
    logic [kvt_pkg::WORD_W-1:0] res_data_reg, res_data_next;
    logic             out_valid_reg, out_valid_next;
    kvt_pkg::status_t out_status_reg, out_status_next;
    logic [kvt_pkg::WORD_W-1:0] out_data_reg, out_data_next;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        sweep_next      = sweep_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;

        req.ready = (state_reg == kvt_pkg::S_IDLE);

        cmd.commit     = 1'b0;
        cmd.op         = op_reg;
        cmd.found      = chain_res.hit;
        cmd.key        = key_reg;
        cmd.value      = val_reg;
        cmd.last_key   = chain_res.last_key;
        cmd.last_value = chain_res.last_value;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            kvt_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = kvt_pkg::opcode_t'(req.opcode);
                    key_next   = kvt_pkg::canon_word(req.search_key, KEY_BYTES);
                    val_next   = kvt_pkg::canon_word(req.data_word, VALUE_BYTES);
                    sweep_next = '0;
                    if (kvt_pkg::opcode_t'(req.opcode) == kvt_pkg::OP_CLEAR)
                    begin
                        count_next      = '0;
                        res_status_next = kvt_pkg::ST_OK;
                        res_data_next   = '0;
                        state_next      = kvt_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = kvt_pkg::S_SWEEP;
                    end
                end
            end
            kvt_pkg::S_SWEEP:
            begin
                if (sweep_reg == CNT_W'(ENTRIES - 1))
                begin
                    state_next = kvt_pkg::S_COMMIT;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            kvt_pkg::S_COMMIT:
            begin
                cmd.commit      = 1'b1;
                res_status_next = kvt_pkg::ST_OK;
                res_data_next   = '0;
                unique case (op_reg)
                    kvt_pkg::OP_PUT:
                    begin
                        if (!chain_res.hit)
                        begin
                            if (count_reg == CNT_W'(ENTRIES))
                            begin
                                res_status_next = kvt_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    kvt_pkg::OP_GET:
                    begin
                        if (chain_res.hit)
                        begin
                            res_data_next = chain_res.value;
                        end
                        else
                        begin
                            res_status_next = kvt_pkg::ST_NOT_FOUND;
                        end
                    end
                    kvt_pkg::OP_DEL:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = kvt_pkg::ST_EMPTY;
                        end
                        else if (!chain_res.hit)
                        begin
                            res_status_next = kvt_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = kvt_pkg::S_DONE;
            end
            kvt_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    state_next      = kvt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kvt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvt_pkg::S_IDLE;
            count_reg     <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.read_data = out_data_reg;
    assign count         = count_reg;

endmodule

// ----- hw/rtl/key_value_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table: associative store of up to ENTRIES key/value pairs
// Requests (put, get, delete, clear) enter on req, one response per request
// leaves on rsp; both are valid/ready channels, a transfer on each edge with
// valid and ready high. Keys and values end at their first zero byte.
// Each entry lives in a cell of a chain. A request is broadcast to all cells;
// each cell compares its key and merges its hit and, for the last live entry,
// its pair into a record that moves one cell per cycle. Once the record has
// left the chain, the update is committed in the commit state and the result
// is loaded into the response register.
// A put, get or delete passes the sweep, commit and done states before the next
// ready; a clear goes from idle straight to the done state.
// The response register parts the channels: the next request is taken while
// an earlier response still waits, and a stalled receiver holds the block
// only once a second result is ready.
// Reset empties the table (entry count zero) and drops any pending response;
// entry storage is not cleared.
// ----------------------------------------------------------------------------
module key_value_table #(
    parameter int ENTRIES     = kvt_pkg::DEF_ENTRIES,
    parameter int KEY_BYTES   = kvt_pkg::DEF_KEY_BYTES,
    parameter int VALUE_BYTES = kvt_pkg::DEF_VALUE_BYTES
) (
    input  logic      clk,
    input  logic      rst_n,
    kvt_req_if.sink   req,
    kvt_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    kvt_pkg::cmd_t    cmd;
    logic [CNT_W-1:0] count;
    kvt_pkg::chain_t  chain [ENTRIES+1];

    assign chain[0] = '0;

    kvt_ctrl #(
        .ENTRIES     (ENTRIES),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BYTES (VALUE_BYTES),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .chain_res (chain[ENTRIES]),
        .cmd       (cmd),
        .count     (count)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kvt_cell #(
            .KEY_W   (KEY_BYTES * 8),
            .VALUE_W (VALUE_BYTES * 8),
            .CNT_W   (CNT_W)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .index     (CNT_W'(i)),
            .count     (count),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

endmodule

// ----- hw/rtl/kvt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_checker: port-level checks of the key/value table
// Tracks requests in flight and checks response ordering and content rules.
// ----------------------------------------------------------------------------
module kvt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [63:0] rsp_read_data
);

    logic [1:0] pending_reg, pending_next;
    logic       req_xfer;
    logic       rsp_xfer;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_xfer && !rsp_xfer)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!req_xfer && rsp_xfer)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response without an outstanding request");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more than two requests in flight");

    a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != kvt_pkg::ST_OK |-> rsp_read_data == '0)
        else $error("read data on a failed request");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_read_data))
        else $error("stalled response changed");

endmodule

bind key_value_table kvt_checker u_kvt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_read_data (rsp.read_data)
);
